FILE: src/vector_to_hsv_color_assert.svh
// Assertion macros shared by the vector to HSV color block.
`ifndef VECTOR_TO_HSV_COLOR_ASSERT_SVH
`define VECTOR_TO_HSV_COLOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define V2H_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("v2h: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define V2H_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("v2h: next-cycle check failed");

`endif

FILE: src/v2h_pkg.sv
// Types, constants and tables of the vector to HSV color block.
package v2h_pkg;

    localparam int VEC_W        = 16;
    localparam int CX_W         = 64;
    localparam int CX_SHIFT     = 60 - VEC_W;
    localparam int Z_W          = 34;
    localparam int CORDIC_STEPS = 28;
    localparam int SQ_W         = 2 * VEC_W;
    localparam int LEN_W        = 16;
    localparam int LEN2_W       = 2 * LEN_W;
    localparam int QUO_W        = 32;
    localparam int DIV_STEPS    = QUO_W;
    localparam int ROOT_W       = QUO_W / 2;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int SQ_REM_W     = ROOT_W + 2;
    localparam int SAT_W        = ROOT_W + 1;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;

    localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;
    localparam logic [SAT_W-1:0]   SAT_ONE      = SAT_W'(65536);
    localparam logic [LEN_W-1:0]   FULL_SCALE_RESET  = 16'd500;
    localparam logic [7:0]         VALUE_LEVEL_RESET = 8'd204;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_LEVEL = 8'd1;

    // arctan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
    } vec_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic logic [7:0] sat8(input logic [8:0] v);
        return v[8] ? 8'hFF : v[7:0];
    endfunction

endpackage

FILE: src/v2h_cordic_cell.sv
// One CORDIC vectoring step with its output register.
module v2h_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [v2h_pkg::CX_W-1:0]   cx_in,
    input  logic signed [v2h_pkg::CX_W-1:0]   cy_in,
    input  logic signed [v2h_pkg::Z_W-1:0]    z_in,
    output logic signed [v2h_pkg::CX_W-1:0]   cx,
    output logic signed [v2h_pkg::CX_W-1:0]   cy,
    output logic signed [v2h_pkg::Z_W-1:0]    z
);
    logic signed [v2h_pkg::CX_W-1:0] dx;
    logic signed [v2h_pkg::CX_W-1:0] dy;
    logic signed [v2h_pkg::Z_W-1:0]  step_ang;
    logic signed [v2h_pkg::CX_W-1:0] cx_next;
    logic signed [v2h_pkg::CX_W-1:0] cy_next;
    logic signed [v2h_pkg::Z_W-1:0]  z_next;

    assign dx       = cy_in >>> STEP;
    assign dy       = cx_in >>> STEP;
    assign step_ang = $signed({2'b00, v2h_pkg::ATAN_TURNS[STEP]});

    always_comb
    begin
        if (!cy_in[v2h_pkg::CX_W-1])
        begin
            cx_next = cx_in + dx;
            cy_next = cy_in - dy;
            z_next  = z_in + step_ang;
        end
        else
        begin
            cx_next = cx_in - dx;
            cy_next = cy_in + dy;
            z_next  = z_in - step_ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx <= cx_next;
            cy <= cy_next;
            z  <= z_next;
        end
    end
endmodule

FILE: src/v2h_div_cell.sv
// One restoring division step: one quotient bit per cell.
module v2h_div_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [v2h_pkg::LEN2_W-1:0]    len2,
    input  logic [v2h_pkg::LEN2_W-1:0]    rem_in,
    input  logic [v2h_pkg::QUO_W-1:0]     quo_in,
    output logic [v2h_pkg::LEN2_W-1:0]    rem,
    output logic [v2h_pkg::QUO_W-1:0]     quo
);
    logic [v2h_pkg::LEN2_W:0] r2;
    logic [v2h_pkg::LEN2_W:0] diff;
    logic                     ge;

    assign r2   = {rem_in, 1'b0};
    assign ge   = r2 >= {1'b0, len2};
    assign diff = r2 - {1'b0, len2};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem <= ge ? diff[v2h_pkg::LEN2_W-1:0] : r2[v2h_pkg::LEN2_W-1:0];
            quo <= {quo_in[v2h_pkg::QUO_W-2:0], ge};
        end
    end
endmodule

FILE: src/v2h_sqrt_cell.sv
// One digit step of the integer square root: two radicand bits per cell.
module v2h_sqrt_cell (
    input  logic                            clk,
    input  logic                            en,
    input  logic [v2h_pkg::QUO_W-1:0]       rad_in,
    input  logic [v2h_pkg::ROOT_W-1:0]      root_in,
    input  logic [v2h_pkg::SQ_REM_W-1:0]    rem_in,
    output logic [v2h_pkg::QUO_W-1:0]       rad,
    output logic [v2h_pkg::ROOT_W-1:0]      root,
    output logic [v2h_pkg::SQ_REM_W-1:0]    rem
);
    logic [v2h_pkg::SQ_REM_W+1:0] tmp;
    logic [v2h_pkg::SQ_REM_W+1:0] trial;
    logic [v2h_pkg::SQ_REM_W+1:0] diff;
    logic                         ge;

    assign tmp   = {rem_in, rad_in[v2h_pkg::QUO_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = tmp >= trial;
    assign diff  = tmp - trial;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem  <= ge ? diff[v2h_pkg::SQ_REM_W-1:0] : tmp[v2h_pkg::SQ_REM_W-1:0];
            root <= {root_in[v2h_pkg::ROOT_W-2:0], ge};
            rad  <= {rad_in[v2h_pkg::QUO_W-3:0], 2'b00};
        end
    end
endmodule

FILE: src/vector_to_hsv_color.sv
// Top level: signed 2D vector in, color-wheel RGB8 color out.
`include "vector_to_hsv_color_assert.svh"

// Turns one signed vector per clock, while not stalled, into one RGB8 color.
// Hue is the vector's angle (28 CORDIC cells), saturation its length over
// full_scale_length (a 32-cell restoring divider feeding a 16-cell square
// root chain), and the value level comes from configuration. Every cell is
// a register stage, so one transaction enters and one leaves per clock while
// the pipeline is not stalled. There are 53 register stages, input register
// + squares (2) + divider (32) + root (16) + color math (2), the first one
// loaded at the accepting edge. The whole pipeline moves together:
// vec_stall follows color_stall while a color is waiting. Configuration is
// written through cfg_* (cfg_ready is always high) and must only change
// while no transaction is in flight.
module vector_to_hsv_color #(
    parameter int ANGLE_FRACTION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vec_valid,
    output logic                               vec_stall,
    input  v2h_pkg::vec_t                      vec,
    output logic                               color_valid,
    input  logic                               color_stall,
    output v2h_pkg::rgb_t                      color,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [v2h_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [v2h_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int A        = ANGLE_FRACTION_BITS;
    localparam int H6_W     = A + 3;
    localparam int FS_W     = A + 17;
    localparam int FLAG_DLY = v2h_pkg::CORDIC_STEPS;
    localparam int SF_DLY   = 2 + v2h_pkg::DIV_STEPS + v2h_pkg::SQRT_STEPS
                              - (v2h_pkg::CORDIC_STEPS + 1);
    localparam int FULL_DLY = v2h_pkg::DIV_STEPS + v2h_pkg::SQRT_STEPS;
    localparam int NSTAGE   = 3 + v2h_pkg::DIV_STEPS + v2h_pkg::SQRT_STEPS + 2;
    localparam logic [FS_W-1:0] ONE_FS = FS_W'(1) << (A + 16);

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
    } quad_t;

    typedef struct packed {
        logic [2:0]   sector;
        logic [A-1:0] frac;
    } hue_t;

    // ---------------- configuration ----------------
    logic [v2h_pkg::LEN_W-1:0]  fsl_reg;
    logic [7:0]                 vl_reg;
    logic [v2h_pkg::LEN2_W-1:0] len2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsl_reg <= v2h_pkg::FULL_SCALE_RESET;
            vl_reg  <= v2h_pkg::VALUE_LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                v2h_pkg::REG_FULL_SCALE:  fsl_reg <= cfg_data;
                v2h_pkg::REG_VALUE_LEVEL: vl_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // squared full-scale length; stable long before any transaction uses it
    always_ff @(posedge clk)
    begin
        len2_reg <= v2h_pkg::LEN2_W'(fsl_reg) * v2h_pkg::LEN2_W'(fsl_reg);
    end

    // ---------------- flow control ----------------
    logic              pipe_adv;
    logic [NSTAGE-1:0] vld_reg;

    assign pipe_adv    = !color_valid || !color_stall;
    assign vec_stall   = !pipe_adv;
    assign color_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_adv)
            vld_reg <= {vld_reg[NSTAGE-2:0], vec_valid};
    end

    // ---------------- stage 1: magnitudes and quadrant ----------------
    logic [v2h_pkg::VEC_W-1:0] ax_reg;
    logic [v2h_pkg::VEC_W-1:0] ay_reg;
    quad_t                     quad_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            ax_reg         <= vec.vec_x[v2h_pkg::VEC_W-1] ? v2h_pkg::VEC_W'(-vec.vec_x)
                                                          : vec.vec_x;
            ay_reg         <= vec.vec_y[v2h_pkg::VEC_W-1] ? v2h_pkg::VEC_W'(-vec.vec_y)
                                                          : vec.vec_y;
            quad_reg.xneg  <= vec.vec_x[v2h_pkg::VEC_W-1];
            quad_reg.yneg  <= vec.vec_y[v2h_pkg::VEC_W-1];
            quad_reg.xzero <= vec.vec_x == '0;
            quad_reg.yzero <= vec.vec_y == '0;
        end
    end

    // ---------------- saturation path ----------------
    logic [v2h_pkg::SQ_W-1:0]   sqx_reg;
    logic [v2h_pkg::SQ_W-1:0]   sqy_reg;
    logic [v2h_pkg::LEN2_W-1:0] sumsq_reg;
    logic                       full_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            sqx_reg   <= v2h_pkg::SQ_W'(ax_reg) * v2h_pkg::SQ_W'(ax_reg);
            sqy_reg   <= v2h_pkg::SQ_W'(ay_reg) * v2h_pkg::SQ_W'(ay_reg);
            sumsq_reg <= v2h_pkg::LEN2_W'(sqx_reg + sqy_reg);
            full_reg  <= v2h_pkg::LEN2_W'(sqx_reg + sqy_reg) >= len2_reg;
        end
    end

    // sumsq * 2^32 / len2, one quotient bit per cell
    logic [v2h_pkg::LEN2_W-1:0] drem [v2h_pkg::DIV_STEPS+1];
    logic [v2h_pkg::QUO_W-1:0]  dquo [v2h_pkg::DIV_STEPS+1];

    assign drem[0] = sumsq_reg;
    assign dquo[0] = '0;

    for (genvar i = 0; i < v2h_pkg::DIV_STEPS; i++)
    begin : g_div
        v2h_div_cell u_cell (
            .clk    (clk),
            .en     (pipe_adv),
            .len2   (len2_reg),
            .rem_in (drem[i]),
            .quo_in (dquo[i]),
            .rem    (drem[i+1]),
            .quo    (dquo[i+1])
        );
    end

    logic [v2h_pkg::QUO_W-1:0]    srad  [v2h_pkg::SQRT_STEPS+1];
    logic [v2h_pkg::ROOT_W-1:0]   sroot [v2h_pkg::SQRT_STEPS+1];
    logic [v2h_pkg::SQ_REM_W-1:0] srem  [v2h_pkg::SQRT_STEPS+1];

    assign srad[0]  = dquo[v2h_pkg::DIV_STEPS];
    assign sroot[0] = '0;
    assign srem[0]  = '0;

    for (genvar j = 0; j < v2h_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        v2h_sqrt_cell u_cell (
            .clk     (clk),
            .en      (pipe_adv),
            .rad_in  (srad[j]),
            .root_in (sroot[j]),
            .rem_in  (srem[j]),
            .rad     (srad[j+1]),
            .root    (sroot[j+1]),
            .rem     (srem[j+1])
        );
    end

    logic full_dly_reg [FULL_DLY];

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            full_dly_reg[0] <= full_reg;
            for (int i = 1; i < FULL_DLY; i++)
                full_dly_reg[i] <= full_dly_reg[i-1];
        end
    end

    logic [v2h_pkg::SAT_W-1:0] sat;
    assign sat = full_dly_reg[FULL_DLY-1] ? v2h_pkg::SAT_ONE
                                          : {1'b0, sroot[v2h_pkg::SQRT_STEPS]};

    // ---------------- angle path ----------------
    logic signed [v2h_pkg::CX_W-1:0] ccx [v2h_pkg::CORDIC_STEPS+1];
    logic signed [v2h_pkg::CX_W-1:0] ccy [v2h_pkg::CORDIC_STEPS+1];
    logic signed [v2h_pkg::Z_W-1:0]  ccz [v2h_pkg::CORDIC_STEPS+1];

    assign ccx[0] = $signed(v2h_pkg::CX_W'(ax_reg) << v2h_pkg::CX_SHIFT);
    assign ccy[0] = $signed(v2h_pkg::CX_W'(ay_reg) << v2h_pkg::CX_SHIFT);
    assign ccz[0] = '0;

    for (genvar k = 0; k < v2h_pkg::CORDIC_STEPS; k++)
    begin : g_cordic
        v2h_cordic_cell #(.STEP(k)) u_cell (
            .clk   (clk),
            .en    (pipe_adv),
            .cx_in (ccx[k]),
            .cy_in (ccy[k]),
            .z_in  (ccz[k]),
            .cx    (ccx[k+1]),
            .cy    (ccy[k+1]),
            .z     (ccz[k+1])
        );
    end

    quad_t quad_dly_reg [FLAG_DLY];

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            quad_dly_reg[0] <= quad_reg;
            for (int i = 1; i < FLAG_DLY; i++)
                quad_dly_reg[i] <= quad_dly_reg[i-1];
        end
    end

    quad_t                        qd;
    logic signed [v2h_pkg::Z_W-1:0] zf;
    logic [30:0]                  a_q1;
    logic [32:0]                  turn;
    logic [A-1:0]                 ang;
    logic [H6_W-1:0]              h6;
    hue_t                         hue_next;

    assign qd = quad_dly_reg[FLAG_DLY-1];
    assign zf = ccz[v2h_pkg::CORDIC_STEPS];

    always_comb
    begin
        // quadrant-one angle, exact on the axes
        if (qd.xzero)
            a_q1 = 31'(v2h_pkg::QUARTER_TURN);
        else if (qd.yzero)
            a_q1 = '0;
        else if (zf[v2h_pkg::Z_W-1])
            a_q1 = '0;
        else if (zf > $signed(v2h_pkg::Z_W'(v2h_pkg::QUARTER_TURN)))
            a_q1 = 31'(v2h_pkg::QUARTER_TURN);
        else
            a_q1 = zf[30:0];

        if (!qd.xneg && !qd.yneg)
            turn = 33'(a_q1);
        else if (qd.xneg && !qd.yneg)
            turn = (33'(v2h_pkg::QUARTER_TURN) << 1) - 33'(a_q1);
        else if (qd.xneg)
            turn = (33'(v2h_pkg::QUARTER_TURN) << 1) + 33'(a_q1);
        else
            turn = (33'(v2h_pkg::QUARTER_TURN) << 2) - 33'(a_q1);

        ang             = turn[31 -: A];
        h6              = H6_W'(ang) * H6_W'(6);
        hue_next.sector = h6[H6_W-1 -: 3];
        hue_next.frac   = h6[A-1:0];
    end

    hue_t hue_reg;
    hue_t hue_dly_reg [SF_DLY];

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            hue_reg        <= hue_next;
            hue_dly_reg[0] <= hue_reg;
            for (int i = 1; i < SF_DLY; i++)
                hue_dly_reg[i] <= hue_dly_reg[i-1];
        end
    end

    // ---------------- color math ----------------
    hue_t            hue_s;
    logic [A:0]      omf;
    logic [24:0]     p_prod;
    logic [FS_W-1:0] fs_reg;
    logic [FS_W-1:0] gs_reg;
    logic [7:0]      p_reg;
    logic [2:0]      sec_reg;

    assign hue_s  = hue_dly_reg[SF_DLY-1];
    assign omf    = (A+1)'(1) << A;
    assign p_prod = 25'(vl_reg) * 25'(v2h_pkg::SAT_ONE - sat);

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            fs_reg  <= FS_W'(hue_s.frac) * FS_W'(sat);
            gs_reg  <= FS_W'((omf - (A+1)'(hue_s.frac)) * FS_W'(sat));
            p_reg   <= v2h_pkg::sat8(p_prod[24:16]);
            sec_reg <= hue_s.sector;
        end
    end

    logic [FS_W+7:0] q_prod;
    logic [FS_W+7:0] t_prod;
    logic [7:0]      qv;
    logic [7:0]      tv;
    v2h_pkg::rgb_t   color_next;

    assign q_prod = (FS_W+8)'(vl_reg) * (FS_W+8)'(ONE_FS - fs_reg);
    assign t_prod = (FS_W+8)'(vl_reg) * (FS_W+8)'(ONE_FS - gs_reg);
    assign qv     = v2h_pkg::sat8(q_prod[FS_W+7 -: 9]);
    assign tv     = v2h_pkg::sat8(t_prod[FS_W+7 -: 9]);

    // six-sector mapping
    always_comb
    begin
        case (sec_reg)
            3'd0:    color_next = '{red: vl_reg, green: tv,     blue: p_reg};
            3'd1:    color_next = '{red: qv,     green: vl_reg, blue: p_reg};
            3'd2:    color_next = '{red: p_reg,  green: vl_reg, blue: tv};
            3'd3:    color_next = '{red: p_reg,  green: qv,     blue: vl_reg};
            3'd4:    color_next = '{red: tv,     green: p_reg,  blue: vl_reg};
            default: color_next = '{red: vl_reg, green: p_reg,  blue: qv};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
            color <= color_next;
    end

    // ---------------- checks ----------------
    `V2H_ASSERT_SAME(a_stall_follows_out, 1'b1, vec_stall == (color_valid && color_stall))
    `V2H_ASSERT_NEXT(a_accept_enters, vec_valid && !vec_stall, vld_reg[0])
    `V2H_ASSERT_NEXT(a_frozen_pipe, vec_stall, $stable(vld_reg) && $stable(color))
endmodule

FILE: bench/tb.sv
// Testbench for vector_to_hsv_color: predicted colors checked against every transaction.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Settle beyond the pipeline latency given by the block.
    localparam int SETTLE_CYCLES = 70;
    localparam longint CYCLE_LIMIT = 600000;

    logic                          clk;
    logic                          rst_n;
    logic                          vec_valid;
    logic                          vec_stall;
    v2h_pkg::vec_t                 vec;
    logic                          color_valid;
    logic                          color_stall;
    v2h_pkg::rgb_t                 color;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [v2h_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [v2h_pkg::CFG_DATA_W-1:0] cfg_data;

    vector_to_hsv_color DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .vec_valid   (vec_valid),
        .vec_stall   (vec_stall),
        .vec         (vec),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .color       (color),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Shadow copy of the two configuration registers.
    logic [15:0] shadow_full_scale;
    logic [7:0]  shadow_value_level;

    v2h_pkg::rgb_t pending_colors[$];
    int     error_count;
    int     vectors_sent;
    int     colors_checked;
    longint cycle_count;

    // Sender burst shaping: items left in the current burst, and max gap length.
    int burst_left;
    int max_gap;
    // Receiver stall pattern: 0 never, 1 sparse random, 2 heavy random, 3 long periodic.
    int stall_mode;
    int stall_phase;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Color predictor: CORDIC angle, exact saturation, six-sector HSV.
    // ------------------------------------------------------------------
    function automatic longint unsigned shade_channel(longint unsigned level,
                                                      longint unsigned num, int bits);
        longint unsigned c;
        c = (level * num) >> bits;
        return (c > 255) ? 64'd255 : c;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic v2h_pkg::rgb_t predict_color(v2h_pkg::vec_t v);
        longint          x, y, cx, cy, z, dx, dy;
        longint unsigned ax, ay, sumsq, len2, sat, angle_q1, turn, ang, h6, sector;
        longint unsigned frac, one_a, level, p, q, t;
        v2h_pkg::rgb_t   c;
        x = v.vec_x;
        y = v.vec_y;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        sumsq = ax * ax + ay * ay;
        len2 = longint'(shadow_full_scale) * longint'(shadow_full_scale);

        // a zero full scale length lands here too: every vector is fully saturated
        if (sumsq >= len2)
            sat = 65536;
        else
            sat = int_sqrt((sumsq << 32) / len2);

        if (x == 0)
            angle_q1 = v2h_pkg::QUARTER_TURN;
        else if (y == 0)
            angle_q1 = 0;
        else
        begin
            cx = longint'(ax << v2h_pkg::CX_SHIFT);
            cy = longint'(ay << v2h_pkg::CX_SHIFT);
            z = 0;
            for (int i = 0; i < v2h_pkg::CORDIC_STEPS; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0)
                begin
                    cx += dx;
                    cy -= dy;
                    z += longint'(v2h_pkg::ATAN_TURNS[i]);
                end
                else
                begin
                    cx -= dx;
                    cy += dy;
                    z -= longint'(v2h_pkg::ATAN_TURNS[i]);
                end
            end
            if (z < 0)
                z = 0;
            if (z > longint'(v2h_pkg::QUARTER_TURN))
                z = v2h_pkg::QUARTER_TURN;
            angle_q1 = z;
        end

        // fold into four quadrants, mod one turn
        if (x >= 0 && y >= 0)
            turn = angle_q1;
        else if (x < 0 && y >= 0)
            turn = 2 * longint'(v2h_pkg::QUARTER_TURN) - angle_q1;
        else if (x < 0)
            turn = 2 * longint'(v2h_pkg::QUARTER_TURN) + angle_q1;
        else
            turn = 4 * longint'(v2h_pkg::QUARTER_TURN) - angle_q1;
        turn &= 64'hFFFF_FFFF;

        ang = turn >> (32 - 16);
        h6 = ang * 6;
        sector = h6 >> 16;
        one_a = 64'd1 << 16;
        frac = h6 & (one_a - 1);

        level = shadow_value_level;
        p = shade_channel(level, 65536 - sat, 16);
        q = shade_channel(level, (one_a << 16) - frac * sat, 32);
        t = shade_channel(level, (one_a << 16) - (one_a - frac) * sat, 32);

        case (sector)
            0:       c = '{level[7:0], t[7:0], p[7:0]};
            1:       c = '{q[7:0], level[7:0], p[7:0]};
            2:       c = '{p[7:0], level[7:0], t[7:0]};
            3:       c = '{p[7:0], q[7:0], level[7:0]};
            4:       c = '{t[7:0], p[7:0], level[7:0]};
            default: c = '{level[7:0], p[7:0], q[7:0]};
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        v2h_pkg::rgb_t want;
        if (rst_n && color_valid && !color_stall)
        begin
            if (pending_colors.size() == 0)
                report_mismatch($sformatf("unexpected color %h", color));
            else
            begin
                want = pending_colors.pop_front();
                colors_checked++;
                if (color.red !== want.red)
                    report_mismatch($sformatf("red %0d, want %0d", color.red, want.red));
                if (color.green !== want.green)
                    report_mismatch($sformatf("green %0d, want %0d",
                                              color.green, want.green));
                if (color.blue !== want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", color.blue, want.blue));
            end
        end
    end

    // Receiver backpressure; the mode is switched per test phase.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            0:       color_stall <= 1'b0;
            1:       color_stall <= ($urandom_range(0, 9) == 0);
            2:       color_stall <= ($urandom_range(0, 1) == 0);
            default: color_stall <= ((stall_phase % 40) >= 28);
        endcase
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one vector transaction. Valid stays high across a burst; a gap
    // drops it for a random number of cycles.
    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y);
        v2h_pkg::vec_t item;
        item.vec_x = x;
        item.vec_y = y;
        vec_valid <= 1'b1;
        vec <= item;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        pending_colors.push_back(predict_color(item));
        vectors_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if (max_gap > 0)
            begin
                vec_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap))
                    @(posedge clk);
            end
        end
    endtask

    // Drain the pipe, then write one register while the block is idle.
    task automatic write_register(logic [v2h_pkg::CFG_IDX_W-1:0] idx,
                                  logic [v2h_pkg::CFG_DATA_W-1:0] data);
        vec_valid <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        // out-of-range indexes are dropped by the block; upper data bits ignored for the value level
        if (idx == v2h_pkg::REG_FULL_SCALE)
            shadow_full_scale = data;
        else if (idx == v2h_pkg::REG_VALUE_LEVEL)
            shadow_value_level = data[7:0];
    endtask

    // Random component: mostly short vectors so saturation spans its range,
    // some full-width values so every input bit toggles.
    function automatic logic signed [15:0] random_component();
        int width;
        logic [15:0] raw;
        width = $urandom_range(1, 16);
        raw = $urandom;
        if ($urandom_range(0, 3) == 0)
            return raw;
        return $signed(raw) >>> (16 - width);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Axis cases, zero vector, extremes, quadrant and sector edges.
    task automatic test_directed();
        stall_mode = 0;
        max_gap = 0;
        send_vector(0, 0);
        send_vector(16'sd32767, 0);
        send_vector(-16'sd32768, 0);
        send_vector(0, 16'sd32767);
        send_vector(0, -16'sd32768);
        send_vector(-16'sd32768, -16'sd32768);
        send_vector(16'sd32767, 16'sd32767);
        send_vector(-16'sd32768, 16'sd32767);
        send_vector(16'sd32767, -16'sd32768);
        send_vector(1, -1);
        send_vector(-1, 1);
        send_vector(-1, -1);
        send_vector(1, 1);
        send_vector(0, -1);
        send_vector(-1, 0);
        // near the 60/120/240/300 degree sector borders
        send_vector(250, 433);
        send_vector(-250, 433);
        send_vector(-250, -433);
        send_vector(250, -433);
        send_vector(353, 354);
        send_vector(499, 0);
        send_vector(300, 400);
        send_vector(301, 400);
    endtask

    // Register extremes, ignored indexes and zero full scale length.
    task automatic test_registers();
        write_register(v2h_pkg::REG_FULL_SCALE, 16'd0);
        write_register(v2h_pkg::REG_VALUE_LEVEL, 16'hFF00);
        send_vector(0, 0);
        send_vector(3, -7);
        send_vector(-16'sd32768, 16'sd32767);
        write_register(v2h_pkg::REG_FULL_SCALE, 16'd1);
        write_register(v2h_pkg::REG_VALUE_LEVEL, 16'd255);
        send_vector(0, 0);
        send_vector(1, 0);
        send_vector(0, -1);
        write_register(v2h_pkg::REG_FULL_SCALE, 16'd65535);
        write_register(v2h_pkg::REG_VALUE_LEVEL, 16'd0);
        send_vector(16'sd32767, 16'sd32767);
        send_vector(-16'sd32768, -16'sd32768);
        write_register(8'd2, 16'd77);
        write_register(8'hFF, 16'hFFFF);
        send_vector(1234, -4321);
    endtask

    // Random vectors across several register settings and pacing styles.
    task automatic test_random();
        logic [15:0] lengths [6] = '{16'd500, 16'd1, 16'd65535, 16'd0, 16'd46341, 16'd0};
        logic [15:0] levels  [6] = '{16'd204, 16'd255, 16'd0, 16'd17, 16'd255, 16'd128};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_register(v2h_pkg::REG_FULL_SCALE,
                           (phase == 5) ? 16'($urandom_range(1, 65535)) : lengths[phase]);
            write_register(v2h_pkg::REG_VALUE_LEVEL,
                           (phase == 5) ? 16'($urandom) : levels[phase]);
            stall_mode = phase % 4;
            max_gap = (phase % 3) * 4;
            for (int n = 0; n < 250; n++)
                send_vector(random_component(), random_component());
        end
        vec_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        vec_valid = 1'b0;
        vec = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        color_stall = 1'b0;
        stall_mode = 0;
        stall_phase = 0;
        burst_left = 0;
        max_gap = 0;
        error_count = 0;
        vectors_sent = 0;
        colors_checked = 0;
        cycle_count = 0;
        shadow_full_scale = v2h_pkg::FULL_SCALE_RESET;
        shadow_value_level = v2h_pkg::VALUE_LEVEL_RESET;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_registers();
        test_random();

        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("%0d vectors sent, %0d colors checked", vectors_sent, colors_checked);
        $display("covered axes, extremes, zero vector and six register settings");
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/v2h_pkg.sv
src/v2h_cordic_cell.sv
src/v2h_div_cell.sv
src/v2h_sqrt_cell.sv
src/vector_to_hsv_color.sv
bench/tb.sv
